FILE: sv/button_press_classifier_assert.svh
// assertion macros used by the port checker
`ifndef BUTTON_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_ASSERT_SVH

// property checked on every clock edge outside reset
`define BPC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define BPC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/bpc_pkg.sv
// types, codes and reset values for the button press classifier
package bpc_pkg;

   localparam int unsigned NOW_W      = 32;
   localparam int unsigned MS_W       = 16;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [MS_W-1:0] DEBOUNCE_MS_RESET = 16'd30;
   localparam logic [MS_W-1:0] LONG_MS_RESET     = 16'd1000;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_IDLE  = 2'd0,
      STATUS_HELD  = 2'd1,
      STATUS_SHORT = 2'd2,
      STATUS_LONG  = 2'd3
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ACTIVE_LEVEL    = 2'd0,
      CSR_DEBOUNCE_MS     = 2'd1,
      CSR_LONG_MS         = 2'd2,
      CSR_AUTO_RELEASE_EN = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic            active_level;
      logic [MS_W-1:0] debounce_ms;
      logic [MS_W-1:0] long_ms;
      logic            auto_release_en;
   } cfg_type;

endpackage

FILE: sv/bpc_intf.sv
// channel interfaces: pin samples, classification results, register writes
interface bpc_req_if import bpc_pkg::*;;
   logic             valid;
   logic             ready;
   logic             pin_level;
   logic [NOW_W-1:0] now_ms;

   modport source (output valid, output pin_level, output now_ms, input ready);
   modport sink   (input valid, input pin_level, input now_ms, output ready);
endinterface

interface bpc_rsp_if import bpc_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] press_status;
   logic [NOW_W-1:0]    duration_ms;

   modport source (output valid, output press_status, output duration_ms, input ready);
   modport sink   (input valid, input press_status, input duration_ms, output ready);
endinterface

interface bpc_csr_if import bpc_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/bpc_csr.sv
// configuration registers of the button press classifier
module bpc_csr import bpc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bpc_csr_if.sink   csr,
   output cfg_type   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr_idx_type'(csr.index))
            CSR_ACTIVE_LEVEL:    cfg_in.active_level    = csr.data[0];
            CSR_DEBOUNCE_MS:     cfg_in.debounce_ms     = csr.data[MS_W-1:0];
            CSR_LONG_MS:         cfg_in.long_ms         = csr.data[MS_W-1:0];
            CSR_AUTO_RELEASE_EN: cfg_in.auto_release_en = csr.data[0];
            default:             cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_level    <= 1'b0;
         cfg_ff.debounce_ms     <= DEBOUNCE_MS_RESET;
         cfg_ff.long_ms         <= LONG_MS_RESET;
         cfg_ff.auto_release_en <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/bpc_classify.sv
// press state and single-pass classification of one pin sample
module bpc_classify import bpc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             advance,
   input  logic             pin_level,
   input  logic [NOW_W-1:0] now_ms,
   output status_type       press_status,
   output logic [NOW_W-1:0] duration_ms
);

   logic             was_pressed_ff, was_pressed_in;
   logic [NOW_W-1:0] time_mark_ff, time_mark_in;
   logic             auto_fired_ff, auto_fired_in;

   logic             pressed;
   logic             first;
   logic             fired;
   logic [NOW_W-1:0] base;
   logic [NOW_W-1:0] diff;
   logic [NOW_W-1:0] long_ext;
   logic [NOW_W-1:0] debounce_ext;
   logic             reach_long;
   logic             reach_debounce;

   always_comb begin
      pressed        = (pin_level == cfg.active_level);
      first          = pressed && !was_pressed_ff;
      // a new press starts its mark at this sample
      base           = first ? now_ms : time_mark_ff;
      diff           = now_ms - base;
      fired          = first ? 1'b0 : auto_fired_ff;
      long_ext       = {{(NOW_W-MS_W){1'b0}}, cfg.long_ms};
      debounce_ext   = {{(NOW_W-MS_W){1'b0}}, cfg.debounce_ms};
      reach_long     = (diff >= long_ext);
      reach_debounce = (diff >= debounce_ext);

      was_pressed_in = pressed;
      time_mark_in   = time_mark_ff;
      auto_fired_in  = auto_fired_ff;
      press_status   = STATUS_IDLE;

      if (pressed) begin
         time_mark_in  = base;
         auto_fired_in = fired;
         if (cfg.auto_release_en) begin
            if (fired) begin
               press_status = STATUS_HELD;
            end else if (reach_long) begin
               // mark takes the threshold itself, not the elapsed time
               auto_fired_in = 1'b1;
               time_mark_in  = long_ext;
               press_status  = STATUS_LONG;
            end
         end
      end else if (was_pressed_ff) begin
         time_mark_in = diff;
         if (reach_debounce && !fired) begin
            press_status = reach_long ? STATUS_LONG : STATUS_SHORT;
         end
      end
   end

   assign duration_ms = time_mark_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         was_pressed_ff <= 1'b0;
         time_mark_ff   <= '0;
         auto_fired_ff  <= 1'b0;
      end else if (advance) begin
         was_pressed_ff <= was_pressed_in;
         time_mark_ff   <= time_mark_in;
         auto_fired_ff  <= auto_fired_in;
      end
   end

endmodule

FILE: sv/button_press_classifier.sv
// top level of the button press classifier
// an accepted req beat goes through the sample register, then the result register, before its rsp beat is offered
// one beat per cycle while rsp_ch does not stall; a sample register and a result register split the path
// each req beat gives exactly one rsp beat, in order
// reset (synchronous, active high) empties both registers, clears the press state
// and loads the configuration registers with their defaults
module button_press_classifier import bpc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   bpc_req_if.sink   req_ch,
   bpc_rsp_if.source rsp_ch,
   bpc_csr_if.sink   csr_ch
);

   // sample register
   logic             in_valid_ff;
   logic             in_pin_ff;
   logic [NOW_W-1:0] in_now_ff;

   // result register
   logic             out_valid_ff;
   status_type       out_status_ff;
   logic [NOW_W-1:0] out_duration_ff;

   cfg_type          cfg;
   status_type       status_in;
   logic [NOW_W-1:0] duration_in;
   logic             out_free;
   logic             advance;

   bpc_csr u_bpc_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_ch),
      .cfg   (cfg)
   );

   // result slot is free when empty or being drained this cycle
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   // sample moves into the result register, press state steps with it
   assign advance      = in_valid_ff && out_free;
   // sample register takes a new beat whenever its content leaves
   assign req_ch.ready = !in_valid_ff || advance;

   bpc_classify u_bpc_classify (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .advance      (advance),
      .pin_level    (in_pin_ff),
      .now_ms       (in_now_ff),
      .press_status (status_in),
      .duration_ms  (duration_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_pin_ff <= req_ch.pin_level;
         in_now_ff <= req_ch.now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_status_ff   <= status_in;
         out_duration_ff <= duration_in;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.press_status = out_status_ff;
   assign rsp_ch.duration_ms  = out_duration_ff;

endmodule

FILE: sv/bpc_port_checker.sv
// port-level checks for the button press classifier, bound to the top level
`include "button_press_classifier_assert.svh"

module bpc_port_checker import bpc_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_press_status,
   input logic [NOW_W-1:0]    rsp_duration_ms
);

   // a stalled result beat holds
   `BPC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_press_status) && $stable(rsp_duration_ms), "rsp beat changed while stalled")

   // every accepted sample is followed by rsp valid once it has passed the sample and result registers
   `BPC_ASSERT(a_rsp_latency, clock, reset, req_valid && req_ready |=> ##1 rsp_valid, "no rsp beat two cycles after req beat")

   // a result rises only for a sample accepted through the sample and result registers
   `BPC_ASSERT(a_rsp_origin, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "rsp beat without matching req beat")

   // reset empties the result register
   `BPC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "rsp valid right after reset")

endmodule

bind button_press_classifier bpc_port_checker u_bpc_port_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_press_status (rsp_ch.press_status),
   .rsp_duration_ms  (rsp_ch.duration_ms)
);

FILE: test/bpc_press_checker.sv
// press classification checker: watches all three channels, predicts each result and compares it
module bpc_press_checker import bpc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bpc_req_if          req_ch,
   bpc_rsp_if          rsp_ch,
   bpc_csr_if          csr_ch,
   output int unsigned fail_count,
   output int unsigned pending_count
);

   typedef struct packed {
      status_type       press_status;
      logic [NOW_W-1:0] duration_ms;
   } press_result_type;

   cfg_type          live_cfg;
   logic             held_flag;
   logic [NOW_W-1:0] mark_ms;
   logic             long_fired;
   press_result_type expected_press[$];

   // classify one pin sample and advance the press state
   function automatic press_result_type judge_sample(input logic level,
                                                     input logic [NOW_W-1:0] stamp);
      logic             pressed;
      logic             prev;
      logic [NOW_W-1:0] span;
      press_result_type res;
      pressed          = (level == live_cfg.active_level);
      prev             = held_flag;
      held_flag        = pressed;
      res.press_status = STATUS_IDLE;
      if (pressed) begin
         if (!prev) begin
            mark_ms    = stamp;
            long_fired = 1'b0;
         end
         if (live_cfg.auto_release_en) begin
            span = stamp - mark_ms;
            if (long_fired) begin
               res.press_status = STATUS_HELD;
            end else if (span >= NOW_W'(live_cfg.long_ms)) begin
               // the mark takes the threshold itself, not the elapsed time
               long_fired       = 1'b1;
               mark_ms          = NOW_W'(live_cfg.long_ms);
               res.press_status = STATUS_LONG;
            end
         end
      end else if (prev) begin
         span    = stamp - mark_ms;
         mark_ms = span;
         if (span >= NOW_W'(live_cfg.debounce_ms) && !long_fired)
            res.press_status = (span >= NOW_W'(live_cfg.long_ms)) ? STATUS_LONG : STATUS_SHORT;
      end
      res.duration_ms = mark_ms;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      press_result_type want;
      if (reset) begin
         live_cfg      = '{active_level: 1'b0, debounce_ms: DEBOUNCE_MS_RESET,
                           long_ms: LONG_MS_RESET, auto_release_en: 1'b0};
         held_flag     = 1'b0;
         mark_ms       = '0;
         long_fired    = 1'b0;
         expected_press.delete();
         fail_count    = 0;
         pending_count = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_idx_type'(csr_ch.index))
               CSR_ACTIVE_LEVEL:    live_cfg.active_level    = csr_ch.data[0];
               CSR_DEBOUNCE_MS:     live_cfg.debounce_ms     = csr_ch.data[MS_W-1:0];
               CSR_LONG_MS:         live_cfg.long_ms         = csr_ch.data[MS_W-1:0];
               CSR_AUTO_RELEASE_EN: live_cfg.auto_release_en = csr_ch.data[0];
               default: ;
            endcase
         end
         // results first, so a beat never matches a sample taken at the same edge
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_press.size() == 0) begin
               $display("%0t: rsp beat with nothing expected, status %0d duration %0d",
                        $time, rsp_ch.press_status, rsp_ch.duration_ms);
               fail_count++;
            end else begin
               want = expected_press.pop_front();
               if (rsp_ch.press_status !== want.press_status) begin
                  $display("%0t: press_status expected %0d got %0d",
                           $time, want.press_status, rsp_ch.press_status);
                  fail_count++;
               end
               if (rsp_ch.duration_ms !== want.duration_ms) begin
                  $display("%0t: duration_ms expected %0d got %0d",
                           $time, want.duration_ms, rsp_ch.duration_ms);
                  fail_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_press.push_back(judge_sample(req_ch.pin_level, req_ch.now_ms));
         pending_count = expected_press.size();
      end
   end

endmodule

FILE: test/tb_top.sv
// testbench top: clock, reset, pin sample stimulus and the final verdict
module tb_top import bpc_pkg::*;;

   logic        clock = 1'b0;
   logic        reset;
   int unsigned fail_count;
   int unsigned pending_count;

   bpc_req_if req_ch ();
   bpc_rsp_if rsp_ch ();
   bpc_csr_if csr_ch ();

   button_press_classifier u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   bpc_press_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .csr_ch        (csr_ch),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // stimulus copy of the settings, used only to shape press sequences
   logic            pressed_level;
   logic [MS_W-1:0] debounce_set;
   logic [MS_W-1:0] long_set;
   logic            auto_set;

   logic [NOW_W-1:0] clock_ms;     // running millisecond time for the next sequence
   bit               no_idle;      // both sides run flat out while set
   int unsigned      beats_sent;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hard stop in case the handshakes hang
   initial begin
      #5_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // per-beat wait of either side
   function automatic int unsigned idle_gap();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   // result side: stall a random number of cycles before taking each beat
   initial begin
      int unsigned stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         stall = idle_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // one pin sample beat; called and returns at a falling edge
   task automatic send_sample(input logic level, input logic [NOW_W-1:0] stamp);
      int unsigned gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      // valid stays high into the next beat when there is no gap
      req_ch.valid     <= 1'b1;
      req_ch.pin_level <= level;
      req_ch.now_ms    <= stamp;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   // drop valid and wait until every result is back and the pipe is empty
   task automatic settle();
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   // all four registers, only once the block has gone quiet
   task automatic apply_settings(input logic level, input logic [MS_W-1:0] debounce,
                                 input logic [MS_W-1:0] long_thr, input logic auto_en);
      settle();
      write_reg(CSR_ACTIVE_LEVEL, CSR_DATA_W'(level));
      write_reg(CSR_DEBOUNCE_MS, debounce);
      write_reg(CSR_LONG_MS, long_thr);
      write_reg(CSR_AUTO_RELEASE_EN, CSR_DATA_W'(auto_en));
      pressed_level = level;
      debounce_set  = debounce;
      long_set      = long_thr;
      auto_set      = auto_en;
   endtask

   // press length: below debounce, near the debounce or long threshold, up to twice long plus 100, or anything
   function automatic logic [NOW_W-1:0] pick_hold();
      logic [NOW_W-1:0] hold;
      case ($urandom_range(0, 9))
         0, 1:    hold = $urandom_range(0, debounce_set);
         2:       hold = debounce_set + $urandom_range(0, 2) - 1;
         3:       hold = long_set + $urandom_range(0, 2) - 1;
         4:       hold = $urandom();
         default: hold = $urandom_range(0, 2 * long_set + 100);
      endcase
      return hold;
   endfunction

   // idle sample, press, a few held samples, release after hold_ms
   task automatic press_run(input logic [NOW_W-1:0] hold_ms, input int unsigned taps);
      logic [NOW_W-1:0] start;
      int unsigned      i;
      send_sample(~pressed_level, clock_ms);
      start = clock_ms + $urandom_range(1, 50);
      send_sample(pressed_level, start);
      for (i = 1; i <= taps; i++)
         send_sample(pressed_level, start + (hold_ms / (taps + 1)) * i);
      // straddle the auto-release threshold while still held
      if (auto_set && $urandom_range(0, 2) == 0) begin
         send_sample(pressed_level, start + long_set - 1);
         send_sample(pressed_level, start + long_set);
         if ($urandom_range(0, 1))
            send_sample(pressed_level, start + long_set + $urandom_range(0, 300));
      end
      send_sample(~pressed_level, start + hold_ms);
      clock_ms = start + hold_ms + $urandom_range(0, 100);
   endtask

   // mostly well-formed presses, the rest stray samples and time jumps
   task automatic random_phase(input int unsigned quota);
      int unsigned stop_at;
      stop_at = beats_sent + quota;
      while (beats_sent < stop_at) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 6) == 0) begin
            repeat ($urandom_range(1, 4))
               send_sample(1'($urandom_range(0, 1)),
                           $urandom_range(0, 1) ? $urandom() : clock_ms + $urandom_range(0, 5000));
         end else begin
            if ($urandom_range(0, 15) == 0)
               clock_ms = $urandom();
            press_run(pick_hold(), $urandom_range(0, 3));
         end
      end
      no_idle = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.pin_level = 1'b0;
      req_ch.now_ms    = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = CSR_ACTIVE_LEVEL;
      csr_ch.data      = '0;
      no_idle          = 1'b0;
      beats_sent       = 0;
      clock_ms         = $urandom();
      pressed_level    = 1'b0;
      debounce_set     = DEBOUNCE_MS_RESET;
      long_set         = LONG_MS_RESET;
      auto_set         = 1'b0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset settings: pressed is pin low, debounce 30, long 1000, no auto-release
      send_sample(1'b1, 32'h0000_0000);   // idle at both ends of the time range
      send_sample(1'b1, 32'hFFFF_FFFF);
      send_sample(1'b0, 32'd100);         // release shorter than debounce
      send_sample(1'b0, 32'd110);
      send_sample(1'b1, 32'd129);
      send_sample(1'b0, 32'd200);         // short, exactly at debounce
      send_sample(1'b1, 32'd230);
      send_sample(1'b0, 32'd300);         // short, one below long
      send_sample(1'b1, 32'd1299);
      send_sample(1'b0, 32'd2000);        // long, exactly at threshold
      send_sample(1'b1, 32'd3000);
      send_sample(1'b0, 32'hFFFF_FFF0);   // long across the time wrap
      send_sample(1'b1, 32'h0000_0400);

      // auto-release: fires once at threshold, then held, release reports nothing
      apply_settings(1'b0, 16'd30, 16'd1000, 1'b1);
      send_sample(1'b0, 32'd5000);
      send_sample(1'b0, 32'd5999);
      send_sample(1'b0, 32'd6000);
      send_sample(1'b0, 32'd6500);
      send_sample(1'b1, 32'd7000);

      // active level flipped while held: next sample reads as a release
      send_sample(1'b0, 32'd8000);
      apply_settings(1'b1, 16'd30, 16'd1000, 1'b1);
      send_sample(1'b0, 32'd8040);
      send_sample(1'b1, 32'd9000);        // zero-length press
      send_sample(1'b0, 32'd9000);

      apply_settings(1'b0, DEBOUNCE_MS_RESET, LONG_MS_RESET, 1'b0);
      random_phase(230);
      apply_settings(1'b1, 16'd0, 16'd0, 1'b0);
      random_phase(230);
      apply_settings(1'b0, 16'hFFFF, 16'hFFFF, 1'b1);
      random_phase(230);
      apply_settings(1'b1, 16'd20, 16'd500, 1'b1);
      random_phase(230);
      apply_settings(1'b0, 16'd50, 16'd40, 1'b0);     // long below debounce
      random_phase(230);
      apply_settings(1'b1, 16'd0, 16'd0, 1'b1);       // auto-release fires on the press itself
      random_phase(230);
      repeat (2) begin
         apply_settings(1'($urandom_range(0, 1)), MS_W'($urandom_range(0, 200)),
                        MS_W'($urandom_range(0, 3000)), 1'($urandom_range(0, 1)));
         random_phase(230);
      end

      settle();
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+sv
sv/bpc_pkg.sv
sv/bpc_intf.sv
sv/bpc_csr.sv
sv/bpc_classify.sv
sv/button_press_classifier.sv
sv/bpc_port_checker.sv
test/bpc_press_checker.sv
test/tb_top.sv
